### sv/nrf_pkg.sv
// ---------------------------------------------------------------------------
// nrf_pkg
// Shared types and constants for the NAL unit RTP fragmenter.
// ---------------------------------------------------------------------------
package nrf_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 21;
   localparam int unsigned PAY_W  = 16;

   // results per input item, at most
   localparam int unsigned MAX_RES   = 4;
   localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

   localparam int unsigned MAX_NAL_BYTES_DEFAULT = 1048576;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = PAY_W;
   localparam logic [CSR_IDX_W-1:0] CSR_CODEC_SELECT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD  = 1'b1;

   localparam logic             CODEC_H264 = 1'b0;
   localparam logic             CODEC_H265 = 1'b1;
   localparam logic [PAY_W-1:0] MAX_PAYLOAD_RESET = 16'd1436;
   localparam logic [PAY_W-1:0] MIN_PAYLOAD       = 16'd8;

   // header building
   localparam logic [BYTE_W-1:0] H264_NRI_MASK  = 8'hE0;
   localparam logic [BYTE_W-1:0] H264_FU_A_TYPE = 8'd28;
   localparam logic [BYTE_W-1:0] H264_TYPE_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] H265_KEEP_MASK = 8'h81;
   localparam logic [BYTE_W-1:0] H265_TYPE_MASK = 8'h7E;
   localparam logic [BYTE_W-1:0] H265_FU_TYPE   = 8'(49 << 1);
   localparam logic [BYTE_W-1:0] FU_S_BIT       = 8'h80;
   localparam logic [BYTE_W-1:0] FU_E_BIT       = 8'h40;

   localparam logic [PAY_W:0] H264_HDR_BYTES = 17'd2;
   localparam logic [PAY_W:0] H265_HDR_BYTES = 17'd3;

   typedef struct packed {
      logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
      logic [RES_IDX_W-1:0]           last_idx;
      logic                           pkt_end;
      logic                           nal_done;
   } nrf_result_type;

endpackage

### sv/nrf_core.sv
// ---------------------------------------------------------------------------
// nrf_core
// Unit state and header building: turns one NAL byte into its result bytes.
// ---------------------------------------------------------------------------
module nrf_core #(
   parameter int unsigned MAX_NAL_BYTES = nrf_pkg::MAX_NAL_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [nrf_pkg::BYTE_W-1:0]  nal_byte,
   input  logic [nrf_pkg::LEN_W-1:0]   nal_length,
   input  logic                        codec_select,
   input  logic [nrf_pkg::PAY_W-1:0]   max_payload,
   output nrf_pkg::nrf_result_type     result
);

   logic [nrf_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [nrf_pkg::PAY_W-1:0]  fill_ff, fill_in;
   logic                       frag_ff, frag_in;
   logic [nrf_pkg::BYTE_W-1:0] hdr_ff [3];
   logic [nrf_pkg::BYTE_W-1:0] hdr_in [3];

   always_comb begin
      logic [nrf_pkg::LEN_W-1:0]     len;
      logic [nrf_pkg::LEN_W-1:0]     rem;
      logic [nrf_pkg::PAY_W-1:0]     mx;
      logic [nrf_pkg::PAY_W-1:0]     fill_base;
      logic [nrf_pkg::PAY_W-1:0]     fill_new;
      logic [nrf_pkg::PAY_W:0]       fill_sum;
      logic [nrf_pkg::LEN_W:0]       hdr_plus_rem;
      logic [nrf_pkg::BYTE_W-1:0]    fu;
      logic                          h265, first, last, frag, pend;

      len = (nal_length == '0) ? nrf_pkg::LEN_W'(1) : nal_length;
      if (32'(len) > 32'(MAX_NAL_BYTES)) begin
         len = nrf_pkg::LEN_W'(MAX_NAL_BYTES);
      end
      mx    = (max_payload < nrf_pkg::MIN_PAYLOAD) ? nrf_pkg::MIN_PAYLOAD : max_payload;
      h265  = (codec_select == nrf_pkg::CODEC_H265);
      rem   = (pos_ff < len) ? (len - pos_ff) : nrf_pkg::LEN_W'(1);
      last  = (rem == nrf_pkg::LEN_W'(1));
      first = (pos_ff == '0);
      frag  = first ? (len > nrf_pkg::LEN_W'(mx)) : frag_ff;
      fill_base = first ? '0 : fill_ff;

      hdr_in = hdr_ff;
      if (first && frag) begin
         if (h265) begin
            hdr_in[0] = (nal_byte & nrf_pkg::H265_KEEP_MASK) | nrf_pkg::H265_FU_TYPE;
            hdr_in[2] = (nal_byte & nrf_pkg::H265_TYPE_MASK) >> 1;
         end else begin
            hdr_in[0] = (nal_byte & nrf_pkg::H264_NRI_MASK) | nrf_pkg::H264_FU_A_TYPE;
            hdr_in[1] = nal_byte & nrf_pkg::H264_TYPE_MASK;
         end
      end

      // start of a follow-on fragment: end bit if the rest fits
      hdr_plus_rem = nrf_pkg::LEN_W'(0) + {1'b0, rem}
                     + (nrf_pkg::LEN_W+1)'(h265 ? nrf_pkg::H265_HDR_BYTES
                                                : nrf_pkg::H264_HDR_BYTES);
      fu = h265 ? hdr_ff[2] : hdr_ff[1];
      if (hdr_plus_rem <= (nrf_pkg::LEN_W+1)'(mx)) begin
         fu = fu | nrf_pkg::FU_E_BIT;
      end

      result.bytes    = {nrf_pkg::MAX_RES{nal_byte}};
      result.last_idx = '0;
      if (!frag) begin
         result.bytes[0] = nal_byte;
      end else if (first) begin
         result.bytes[0] = hdr_in[0];
         if (!h265) begin
            result.bytes[1] = nrf_pkg::FU_S_BIT | hdr_in[1];
            result.last_idx = nrf_pkg::RES_IDX_W'(1);
         end
      end else if ((pos_ff == nrf_pkg::LEN_W'(1)) && h265) begin
         hdr_in[1]       = nal_byte;
         result.bytes[0] = nal_byte;
         result.bytes[1] = nrf_pkg::FU_S_BIT | hdr_ff[2];
         result.last_idx = nrf_pkg::RES_IDX_W'(1);
      end else if (fill_base == '0) begin
         result.bytes[0] = hdr_ff[0];
         if (h265) begin
            result.bytes[1] = hdr_ff[1];
            result.bytes[2] = fu;
            result.bytes[3] = nal_byte;
            result.last_idx = nrf_pkg::RES_IDX_W'(3);
         end else begin
            result.bytes[1] = fu;
            result.bytes[2] = nal_byte;
            result.last_idx = nrf_pkg::RES_IDX_W'(2);
         end
      end else begin
         result.bytes[0] = nal_byte;
      end

      fill_sum = {1'b0, fill_base} + (nrf_pkg::PAY_W+1)'(result.last_idx)
                 + (nrf_pkg::PAY_W+1)'(1);
      if (frag) begin
         fill_new = fill_sum[nrf_pkg::PAY_W] ? '1 : fill_sum[nrf_pkg::PAY_W-1:0];
      end else begin
         fill_new = fill_base;
      end
      pend = last || (frag && (fill_new >= mx));
      result.pkt_end  = pend;
      result.nal_done = pend && last;

      pos_in  = last ? '0 : pos_ff + nrf_pkg::LEN_W'(1);
      fill_in = pend ? '0 : fill_new;
      frag_in = last ? 1'b0 : frag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         frag_ff <= 1'b0;
         hdr_ff  <= '{default: '0};
      end else if (load) begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
         frag_ff <= frag_in;
         hdr_ff  <= hdr_in;
      end
   end

endmodule

### sv/nrf_out_buf.sv
// ---------------------------------------------------------------------------
// nrf_out_buf
// Result register: holds one item's bytes, sends one a cycle unless stalled.
// ---------------------------------------------------------------------------
module nrf_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  nrf_pkg::nrf_result_type     result,
   output logic                        can_load,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nrf_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_packet_end,
   output logic                        rsp_nal_done,
   output logic                        rsp_run_last
);

   logic                             valid_ff, valid_in;
   logic [nrf_pkg::RES_IDX_W-1:0]    idx_ff, idx_in;
   nrf_pkg::nrf_result_type          res_ff;
   logic                             take, at_last;

   assign at_last  = (idx_ff == res_ff.last_idx);
   assign take     = valid_ff && !rsp_stall;
   // free now, or the final byte leaves in this cycle
   assign can_load = !valid_ff || (take && at_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (take) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + nrf_pkg::RES_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = res_ff.bytes[idx_ff];
   assign rsp_run_last   = at_last;
   assign rsp_packet_end = at_last && res_ff.pkt_end;
   assign rsp_nal_done   = at_last && res_ff.nal_done;

endmodule

### sv/nal_unit_rtp_fragmenter.sv
// ---------------------------------------------------------------------------
// nal_unit_rtp_fragmenter
// Splits NAL units into RTP payloads: whole units that fit, else H.264 FU-A or H.265 FU fragments.
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   req_nal_byte, req_nal_length
//  rsp_     out        rsp_valid/rsp_stall   rsp_out_byte, rsp_packet_end,
//                                            rsp_nal_done, rsp_run_last
//  csr_     in         csr_write_en          csr_index, csr_write_data
//
// An item is turned into 1 to 4 result bytes in the cycle it is accepted;
// the result register then sends one byte per cycle while rsp_stall is low
// (1 result for most bytes, up to 4 where fragment headers are inserted).
// The next item is taken in the cycle the final byte leaves. Reset is
// synchronous and clears all unit state and loads the register reset values.
// ---------------------------------------------------------------------------
module nal_unit_rtp_fragmenter #(
   parameter int unsigned MAX_NAL_BYTES = nrf_pkg::MAX_NAL_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [nrf_pkg::BYTE_W-1:0]      req_nal_byte,
   input  logic [nrf_pkg::LEN_W-1:0]       req_nal_length,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [nrf_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_packet_end,
   output logic                            rsp_nal_done,
   output logic                            rsp_run_last,
   input  logic                            csr_write_en,
   input  logic [nrf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nrf_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic                        codec_ff;
   logic [nrf_pkg::PAY_W-1:0]   max_pay_ff;
   logic                        can_load, load;
   nrf_pkg::nrf_result_type     result;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff   <= nrf_pkg::CODEC_H264;
         max_pay_ff <= nrf_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            nrf_pkg::CSR_CODEC_SELECT: codec_ff   <= csr_write_data[0];
            nrf_pkg::CSR_MAX_PAYLOAD:  max_pay_ff <= csr_write_data[nrf_pkg::PAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !can_load;
   assign load      = req_valid && can_load;

   nrf_core #(
      .MAX_NAL_BYTES (MAX_NAL_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .nal_byte     (req_nal_byte),
      .nal_length   (req_nal_length),
      .codec_select (codec_ff),
      .max_payload  (max_pay_ff),
      .result       (result)
   );

   nrf_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .result         (result),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_nal_done   (rsp_nal_done),
      .rsp_run_last   (rsp_run_last)
   );

   // unit completion only closes a packet, on an item's final byte
   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nal_done |-> rsp_packet_end && rsp_run_last)
      else $error("nal_done without packet end on final byte");

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_run_last)
      else $error("packet end before an item's final byte");

   // a new item only enters as the previous item's bytes are all gone
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid || (!rsp_stall && rsp_run_last))
      else $error("item accepted over pending results");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

endmodule
